[rtl/core/mfps_pkg.sv]
// Package for the multi-flow priority send scheduler.
// Holds request/result structs, status codes and state enums; no dependencies.
package mfps_pkg;

  localparam int unsigned PID_W    = 16;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned LIMIT_W  = 6;
  localparam int unsigned MARGIN_W = 2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BUSY   = 2'd1,
    ST_NOSLOT = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_HIGH_LIMIT   = 2'd0,
    REG_MIDDLE_LIMIT = 2'd1,
    REG_LOW_LIMIT    = 2'd2,
    REG_WAIT_MARGIN  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                action;
    logic [PID_W-1:0]    sender_pid;
    logic [1:0]          priority_req;
    logic                is_inner;
    logic [HANDLE_W-1:0] msg_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] out_handle;
    logic                near_full;
  } out_item_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ENQ_SCAN,
    BK_ENQ_LVL,
    BK_ENQ_DO,
    BK_INNER,
    BK_FLOW_POP,
    BK_FLOW_LVL,
    BK_FLOW_TAKE,
    BK_RD_WAIT,
    BK_RESULT
  } bk_state_t;

endpackage

[rtl/core/mfps_front.sv]
// Front end: accepts requests and holds them in a short queue for the back end.
// Depends on mfps_pkg.
module mfps_front
  import mfps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_item,
  output logic     q_valid,
  output in_item_t q_item,
  input  logic     q_pop
);

  in_item_t   buf_r [2];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       rd_r;
  logic       wr_r;
  logic       push;

  // One request is worked at a time, so the queue holds at most one entry.
  assign busy    = (cnt_r != 2'd0) || q_pop;
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = buf_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && q_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (q_pop) rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_r] <= in_item;
  end

endmodule

[rtl/core/mfps_back.sv]
// Back end: flow table, service order, FIFO state and handle memory.
// Depends on mfps_pkg.
module mfps_back
  import mfps_pkg::*;
#(
  parameter int unsigned MAX_FLOWS   = 8,
  parameter int unsigned FIFO_DEPTH  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  in_item_t            q_item,
  output logic                q_pop,
  input  logic [LIMIT_W-1:0]  high_limit,
  input  logic [LIMIT_W-1:0]  middle_limit,
  input  logic [LIMIT_W-1:0]  low_limit,
  input  logic [MARGIN_W-1:0] wait_margin,
  output logic                res_valid,
  output out_item_t           res_item
);

  localparam int unsigned NF   = 3 * (MAX_FLOWS + 1);
  localparam int unsigned FW   = (NF > 1) ? $clog2(NF) : 1;
  localparam int unsigned SW   = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
  localparam int unsigned CW   = $clog2(MAX_FLOWS + 1);
  localparam int unsigned PW   = $clog2(FIFO_DEPTH);
  localparam int unsigned LW   = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned AW   = $clog2(NF * FIFO_DEPTH);
  localparam int unsigned MW   = (LW > LIMIT_W) ? LW : LIMIT_W;

  logic [PID_W-1:0]       key_r   [MAX_FLOWS];
  logic [MAX_FLOWS-1:0]   valid_r;
  logic [SW-1:0]          order_r [MAX_FLOWS];
  logic [CW-1:0]          active_r;
  logic [PW-1:0]          head_r  [NF];
  logic [PW-1:0]          tail_r  [NF];
  logic [LW-1:0]          level_r [NF];
  logic [HANDLE_W-1:0]    mem     [NF*FIFO_DEPTH];
  logic [HANDLE_W-1:0]    rdata_r;

  bk_state_t         st_r, st_nxt;
  in_item_t          it_r;
  logic [1:0]        prio_r;
  logic [FW-1:0]     fidx_r;
  logic [SW-1:0]     slot_r;
  logic              fresh_r;
  logic [CW-1:0]     scan_r;
  logic [CW-1:0]     visits_r;
  logic              final_r;
  logic [LW-1:0]     lvl_r;
  logic [1:0]        status_r;
  logic              nf_r;
  logic              got_r;

  function automatic logic [LIMIT_W-1:0] limit_of(input logic [1:0] p,
      input logic [LIMIT_W-1:0] h, input logic [LIMIT_W-1:0] m,
      input logic [LIMIT_W-1:0] l);
    if (p == 2'd0) return h;
    if (p == 2'd1) return m;
    return l;
  endfunction

  // Ring pointers wrap at the FIFO depth, which need not be a power of two.
  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [LIMIT_W-1:0] cur_lim, cur_thr;
  logic [MW-1:0]      cur_cap;
  logic               lvl_ge_thr, lvl_ge_cap;
  logic [AW-1:0]      addr;

  always_comb begin
    cur_lim = limit_of(prio_r, high_limit, middle_limit, low_limit);
    cur_thr = (cur_lim > LIMIT_W'(wait_margin)) ? cur_lim - LIMIT_W'(wait_margin) : '0;
    cur_cap = (MW'(cur_lim) < MW'(FIFO_DEPTH)) ? MW'(cur_lim) : MW'(FIFO_DEPTH);
    lvl_ge_thr = MW'(lvl_r) >= MW'(cur_thr);
    lvl_ge_cap = MW'(lvl_r) >= cur_cap;
    addr = AW'(fidx_r) * AW'(FIFO_DEPTH);
  end

  logic           match_hit;
  logic [SW-1:0]  match_slot;
  logic           free_hit;
  logic [SW-1:0]  free_slot;
  logic [SW-1:0]  scan_slot;
  logic [1:0]     q_prio;
  logic           q_inner;
  logic           scan_found;
  logic           scan_more;
  logic           no_slot;
  logic           walk_done;
  logic           inner_next;
  logic           inner_fifo;

  assign scan_slot = order_r[scan_r[SW-1:0]];
  assign match_hit = valid_r[scan_slot] && key_r[scan_slot] == it_r.sender_pid;
  assign match_slot = scan_slot;

  assign q_prio     = (q_item.priority_req == 2'd3) ? 2'd2 : q_item.priority_req;
  assign q_inner    = (q_item.sender_pid == '0) && q_item.is_inner;
  assign scan_found = (scan_r < active_r) && match_hit;
  assign scan_more  = (scan_r + 1'b1) < active_r;
  assign no_slot    = !free_hit || (active_r >= CW'(MAX_FLOWS));
  assign walk_done  = (visits_r == '0) || (active_r == '0);
  assign inner_next = (prio_r == 2'd0) || (prio_r == 2'd1 && final_r);
  assign inner_fifo = fidx_r < FW'(3);

  always_comb begin
    free_hit  = 1'b0;
    free_slot = '0;
    for (int i = MAX_FLOWS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_hit  = 1'b1;
        free_slot = SW'(i);
      end
    end
  end

  assign q_pop = (st_r == BK_IDLE) && q_valid;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_item.action) st_nxt = BK_INNER;
          else if (q_inner) st_nxt = BK_ENQ_LVL;
          else st_nxt = BK_ENQ_SCAN;
        end
      end
      BK_ENQ_SCAN: begin
        if (scan_found) st_nxt = BK_ENQ_LVL;
        else if (scan_more) st_nxt = BK_ENQ_SCAN;
        else if (no_slot) st_nxt = BK_RESULT;
        else st_nxt = BK_ENQ_LVL;
      end
      BK_ENQ_LVL:  st_nxt = BK_ENQ_DO;
      BK_ENQ_DO:   st_nxt = BK_RESULT;
      BK_INNER:    st_nxt = BK_FLOW_TAKE;
      BK_FLOW_POP: st_nxt = walk_done ? BK_INNER : BK_FLOW_LVL;
      BK_FLOW_LVL: st_nxt = BK_FLOW_TAKE;
      BK_FLOW_TAKE: begin
        if (lvl_r != '0) st_nxt = BK_RD_WAIT;
        else if (inner_fifo) begin
          if (inner_next) st_nxt = BK_INNER;
          else if (!final_r) st_nxt = BK_FLOW_POP;
          else st_nxt = BK_RD_WAIT;
        end else if (prio_r != 2'd2) st_nxt = BK_FLOW_LVL;
        else st_nxt = BK_FLOW_POP;
      end
      BK_RD_WAIT:  st_nxt = BK_RESULT;
      BK_RESULT:   st_nxt = BK_IDLE;
      default:     st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      active_r <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < int'(NF); i++) begin
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        level_r[i] <= '0;
      end
    end else begin
      res_valid <= (st_r == BK_RESULT);
      case (st_r)
        BK_IDLE: begin
          if (q_valid) begin
            it_r     <= q_item;
            prio_r   <= q_item.action ? 2'd0 : q_prio;
            scan_r   <= '0;
            fresh_r  <= 1'b0;
            nf_r     <= 1'b0;
            got_r    <= 1'b0;
            final_r  <= 1'b0;
            visits_r <= active_r;
            if (q_item.action) begin
              fidx_r <= '0;
            end else if (q_inner) begin
              fidx_r <= FW'(q_prio);
            end
          end
        end
        BK_ENQ_SCAN: begin
          if (scan_found) begin
            slot_r <= match_slot;
            fidx_r <= FW'(3 + 3 * int'(match_slot) + int'(prio_r));
          end else if (scan_more) begin
            scan_r <= scan_r + 1'b1;
          end else if (no_slot) begin
            status_r <= ST_NOSLOT;
            nf_r     <= 1'b0;
          end else begin
            valid_r[free_slot] <= 1'b1;
            key_r[free_slot]   <= it_r.sender_pid;
            order_r[active_r[SW-1:0]] <= free_slot;
            active_r <= active_r + 1'b1;
            for (int p = 0; p < 3; p++) begin
              head_r[3 + 3 * int'(free_slot) + p]  <= '0;
              tail_r[3 + 3 * int'(free_slot) + p]  <= '0;
              level_r[3 + 3 * int'(free_slot) + p] <= '0;
            end
            fresh_r <= 1'b1;
            slot_r  <= free_slot;
            fidx_r  <= FW'(3 + 3 * int'(free_slot) + int'(prio_r));
          end
        end
        BK_ENQ_LVL: begin
          lvl_r <= level_r[fidx_r];
        end
        BK_ENQ_DO: begin
          nf_r <= lvl_ge_thr;
          if ((!fresh_r && lvl_ge_thr) || lvl_ge_cap) begin
            status_r <= ST_BUSY;
          end else begin
            status_r <= ST_OK;
            mem[addr + AW'(tail_r[fidx_r])] <= it_r.msg_handle;
            tail_r[fidx_r]  <= next_ptr(tail_r[fidx_r]);
            level_r[fidx_r] <= level_r[fidx_r] + 1'b1;
          end
        end
        // Inner flow pass: high, middle, and on the final pass low too.
        BK_INNER: begin
          lvl_r <= level_r[fidx_r];
        end
        BK_FLOW_POP: begin
          if (walk_done) begin
            final_r <= 1'b1;
            prio_r  <= 2'd0;
            fidx_r  <= '0;
          end else begin
            slot_r <= order_r[0];
            for (int i = 1; i < int'(MAX_FLOWS); i++) begin
              if (CW'(i) < active_r) order_r[i-1] <= order_r[i];
            end
            active_r <= active_r - 1'b1;
            visits_r <= visits_r - 1'b1;
            prio_r   <= 2'd0;
            fidx_r   <= FW'(3 + 3 * int'(order_r[0]));
          end
        end
        BK_FLOW_LVL: begin
          lvl_r <= level_r[fidx_r];
        end
        BK_FLOW_TAKE: begin
          nf_r <= lvl_ge_thr;
          if (lvl_r != '0) begin
            rdata_r <= mem[addr + AW'(head_r[fidx_r])];
            head_r[fidx_r]  <= next_ptr(head_r[fidx_r]);
            level_r[fidx_r] <= level_r[fidx_r] - 1'b1;
            got_r    <= 1'b1;
            status_r <= ST_OK;
            if (!inner_fifo) begin
              order_r[active_r[SW-1:0]] <= slot_r;
              active_r <= active_r + 1'b1;
            end
          end else if (inner_fifo) begin
            if (inner_next) begin
              prio_r <= prio_r + 2'd1;
              fidx_r <= fidx_r + 1'b1;
            end else if (final_r) begin
              status_r <= ST_EMPTY;
            end
          end else if (prio_r != 2'd2) begin
            prio_r <= prio_r + 2'd1;
            fidx_r <= fidx_r + 1'b1;
          end else begin
            valid_r[slot_r] <= 1'b0;
          end
        end
        BK_RESULT: begin
          res_item.status     <= status_r;
          res_item.near_full  <= nf_r;
          res_item.out_handle <= got_r ? rdata_r : '0;
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/multi_flow_priority_send_scheduler_top.sv]
// Top level of the multi-flow priority send scheduler.
// Depends on mfps_pkg, mfps_front and mfps_back.
//
// One request is worked at a time; the next one may be taken while the back end
// works and then waits in the queue. An inner enqueue reads the FIFO level and
// then writes the handle if the level allows; a flow enqueue first compares
// service-order entries, and a new flow with no free slot is refused once the
// scan ends. A dequeue examines the inner FIFOs and the flows taken from the
// service order in turn. The result appears for one cycle on out_valid; the
// receiver cannot stall it and must take it then.
module multi_flow_priority_send_scheduler_top
  import mfps_pkg::*;
#(
  parameter int unsigned MAX_FLOWS   = 8,
  parameter int unsigned FIFO_DEPTH  = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  in_item_t      in_item,
  output logic          out_valid,
  output out_item_t     out_item,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [5:0]    cfg_wdata
);

  logic [LIMIT_W-1:0]  high_r, middle_r, low_r;
  logic [MARGIN_W-1:0] margin_r;
  logic                q_valid, q_pop;
  in_item_t            q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r   <= LIMIT_W'(32);
      middle_r <= LIMIT_W'(32);
      low_r    <= LIMIT_W'(32);
      margin_r <= MARGIN_W'(2);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_HIGH_LIMIT:   high_r   <= cfg_wdata;
        REG_MIDDLE_LIMIT: middle_r <= cfg_wdata;
        REG_LOW_LIMIT:    low_r    <= cfg_wdata;
        REG_WAIT_MARGIN:  margin_r <= cfg_wdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  mfps_front u_front (
    .clk, .rst_n, .start, .busy, .in_item,
    .q_valid, .q_item, .q_pop
  );

  mfps_back #(
    .MAX_FLOWS(MAX_FLOWS), .FIFO_DEPTH(FIFO_DEPTH)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .high_limit(high_r), .middle_limit(middle_r), .low_limit(low_r),
    .wait_margin(margin_r),
    .res_valid(out_valid), .res_item(out_item)
  );

endmodule
